@@ hdl/ffsa_pkg.sv @@
// Shared types and constants for the first-fit slot allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ffsa_pkg;

    localparam int SLOTS_DEF       = 64;
    localparam int AMOUNT_BITS_DEF = 16;

    localparam int IDX_W   = 6;   // slot_index / chosen_slot field width
    localparam int AMT_F_W = 16;  // amount field width on the stream
    localparam int CNT_W   = 16;  // unplaced counter width
    localparam int CFG_W   = 7;   // basket_count width

    localparam logic [CFG_W-1:0] BASKET_RESET = CFG_W'(64);
    localparam logic [CNT_W-1:0] CNT_MAX      = {CNT_W{1'b1}};

    typedef enum logic {
        MODE_LOAD  = 1'b0,
        MODE_PLACE = 1'b1
    } mode_t;

    // Control part of a transaction as it walks down the cell chain.
    typedef struct packed {
        logic              valid;
        mode_t             mode;
        logic [IDX_W-1:0]  idx;
        logic              placed;
        logic [IDX_W-1:0]  chosen;
    } ffsa_tok_t;

endpackage

@@ hdl/first_fit_slot_allocator.sv @@
// First-fit slot allocator: a chain of SLOTS cells, one per slot, followed by an output stage.
// Pipeline: SLOTS cell stages, then the output register, between input transaction and result.
// Throughput: one transaction per cycle; the whole chain stalls while the output register waits.
// Reset: every slot marked used, unplaced count zero, basket_count 64; capacities not reset.
// Depends on ffsa_pkg, ffsa_cell, ffsa_out_stage.
`timescale 1ns / 1ps

module first_fit_slot_allocator
    import ffsa_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int AMOUNT_BITS = AMOUNT_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [23:0]      s_axis_tdata,   // slot_index[5:0], amount[21:6], zero pad
    input  logic [0:0]       s_axis_tuser,   // mode[0]
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // chosen_slot[5:0], unplaced_count[21:6], zero pad
    output logic [0:0]       m_axis_tuser,   // placed[0]
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    logic [CFG_W-1:0] basket_reg, basket_next;
    logic             adv;

    ffsa_tok_t              tok_chain [SLOTS+1];
    logic [AMOUNT_BITS-1:0] amt_chain [SLOTS+1];
    logic [AMOUNT_BITS+AMT_F_W-1:0] amt_ext;

    logic             res_placed;
    logic [IDX_W-1:0] res_chosen;
    logic [CNT_W-1:0] res_count;

    assign cfg_ready   = 1'b1;
    assign basket_next = (cfg_valid && cfg_ready) ? cfg_data : basket_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            basket_reg <= BASKET_RESET;
        else
            basket_reg <= basket_next;
    end

    assign s_axis_tready = adv;

    // keep the low AMOUNT_BITS of the field, zero-extended when wider
    assign amt_ext = {{AMOUNT_BITS{1'b0}}, s_axis_tdata[IDX_W +: AMT_F_W]};

    always_comb
    begin
        tok_chain[0].valid  = s_axis_tvalid;
        tok_chain[0].mode   = mode_t'(s_axis_tuser[0]);
        tok_chain[0].idx    = s_axis_tdata[IDX_W-1:0];
        tok_chain[0].placed = 1'b0;
        tok_chain[0].chosen = '0;
    end
    assign amt_chain[0] = amt_ext[AMOUNT_BITS-1:0];

    for (genvar k = 0; k < SLOTS; k++)
    begin : g_cell
        ffsa_cell #(
            .INDEX       (k),
            .AMOUNT_BITS (AMOUNT_BITS)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .basket  (basket_reg),
            .tok_in  (tok_chain[k]),
            .amt_in  (amt_chain[k]),
            .tok_out (tok_chain[k+1]),
            .amt_out (amt_chain[k+1])
        );
    end

    ffsa_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .tok_in     (tok_chain[SLOTS]),
        .out_ready  (m_axis_tready),
        .adv        (adv),
        .out_valid  (m_axis_tvalid),
        .out_placed (res_placed),
        .out_chosen (res_chosen),
        .out_count  (res_count)
    );

    assign m_axis_tdata = {2'b00, res_count, res_chosen};
    assign m_axis_tuser = res_placed;

endmodule

@@ hdl/ffsa_cell.sv @@
// One slot of the allocator: capacity, used mark and a token stage.
// Depends on ffsa_pkg.
`timescale 1ns / 1ps

module ffsa_cell
    import ffsa_pkg::*;
#(
    parameter int INDEX       = 0,
    parameter int AMOUNT_BITS = AMOUNT_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  logic [CFG_W-1:0]       basket,
    input  ffsa_tok_t              tok_in,
    input  logic [AMOUNT_BITS-1:0] amt_in,
    output ffsa_tok_t              tok_out,
    output logic [AMOUNT_BITS-1:0] amt_out
);

    localparam bit               ADDRESSABLE = (INDEX < (1 << IDX_W));
    localparam logic [IDX_W-1:0] K_LOW       = IDX_W'(INDEX % (1 << IDX_W));

    logic [AMOUNT_BITS-1:0] cap_reg, cap_next;
    logic                   used_reg, used_next;
    ffsa_tok_t              tok_reg, tok_next;
    logic [AMOUNT_BITS-1:0] amt_reg, amt_next;

    logic in_basket;
    logic load_hit;
    logic grant;

    assign in_basket = (32'(INDEX) < 32'(basket));

    assign load_hit = tok_in.valid && (tok_in.mode == MODE_LOAD) && ADDRESSABLE
                      && (tok_in.idx == K_LOW);

    // first free fitting cell within the basket along the chain claims the request
    assign grant = tok_in.valid && (tok_in.mode == MODE_PLACE) && !tok_in.placed
                   && !used_reg && in_basket && (cap_reg >= amt_in);

    always_comb
    begin
        cap_next  = cap_reg;
        used_next = used_reg;
        tok_next  = tok_reg;
        amt_next  = amt_reg;
        if (adv)
        begin
            tok_next = tok_in;
            amt_next = amt_in;
            if (load_hit)
            begin
                cap_next  = amt_in;
                used_next = 1'b0;
            end
            if (grant)
            begin
                used_next       = 1'b1;
                tok_next.placed = 1'b1;
                tok_next.chosen = K_LOW;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b1;
            tok_reg  <= '0;
        end
        else
        begin
            used_reg <= used_next;
            tok_reg  <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cap_reg <= cap_next;
        amt_reg <= amt_next;
    end

    assign tok_out = tok_reg;
    assign amt_out = amt_reg;

    a_grant_sets_used: assert property (@(posedge clk) disable iff (!rst_n)
        adv && grant |=> used_reg)
        else $error("granted slot not marked used");

    a_load_frees: assert property (@(posedge clk) disable iff (!rst_n)
        adv && load_hit |=> !used_reg && (cap_reg == $past(amt_in)))
        else $error("load did not free slot");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(used_reg) && $stable(tok_reg))
        else $error("cell changed during stall");

endmodule

@@ hdl/ffsa_out_stage.sv @@
// Output register and saturating unplaced counter at the end of the chain.
// Depends on ffsa_pkg.
`timescale 1ns / 1ps

module ffsa_out_stage
    import ffsa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  ffsa_tok_t        tok_in,
    input  logic             out_ready,
    output logic             adv,
    output logic             out_valid,
    output logic             out_placed,
    output logic [IDX_W-1:0] out_chosen,
    output logic [CNT_W-1:0] out_count
);

    logic             valid_reg, valid_next;
    logic             placed_reg, placed_next;
    logic [IDX_W-1:0] chosen_reg, chosen_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             take;

    assign adv  = !valid_reg || out_ready;
    assign take = adv && tok_in.valid;

    always_comb
    begin
        valid_next  = adv ? tok_in.valid : valid_reg;
        placed_next = placed_reg;
        chosen_next = chosen_reg;
        cnt_next    = cnt_reg;
        if (take)
        begin
            placed_next = tok_in.placed;
            chosen_next = tok_in.chosen;
            if ((tok_in.mode == MODE_LOAD) && (tok_in.idx == '0))
                cnt_next = '0;
            else if ((tok_in.mode == MODE_PLACE) && !tok_in.placed && (cnt_reg != CNT_MAX))
                cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        placed_reg <= placed_next;
        chosen_reg <= chosen_next;
    end

    assign out_valid  = valid_reg;
    assign out_placed = placed_reg;
    assign out_chosen = chosen_reg;
    assign out_count  = cnt_reg;

    a_cnt_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        take && (tok_in.mode == MODE_PLACE) && (cnt_reg == CNT_MAX) |=> cnt_reg == CNT_MAX)
        else $error("unplaced counter wrapped");

    a_cnt_only_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(cnt_reg))
        else $error("counter moved without a transaction");

    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_ready |=> valid_reg && $stable(placed_reg) && $stable(chosen_reg))
        else $error("result changed while waiting");

endmodule
